[rtl/circle_fan_tessellator_defines.svh]
// assertion helpers for the rtl
`ifndef CIRCLE_FAN_TESSELLATOR_DEFINES_SVH
`define CIRCLE_FAN_TESSELLATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CFT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define CFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cft_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cft_pkg;

   localparam int unsigned MAX_SEGMENTS_DEF = 34;
   localparam int unsigned SINE_TABLE_DEPTH = 1024;
   localparam int unsigned ANGLE_W          = $clog2(SINE_TABLE_DEPTH);
   localparam int unsigned QUARTER          = SINE_TABLE_DEPTH / 4;
   localparam int unsigned QUARTER_W        = $clog2(QUARTER);

   localparam int unsigned COORD_W  = 24;
   localparam int unsigned RADIUS_W = 23;
   localparam int unsigned CAP_W    = 6;
   localparam int unsigned COLOR_W  = 32;
   localparam int unsigned ZOOM_W   = 16;
   localparam int unsigned SIZE_W   = ZOOM_W + RADIUS_W;
   localparam int unsigned SEG_W    = 7;
   localparam int unsigned TRIG_W   = 16;
   localparam int unsigned PROD_W   = RADIUS_W + 1 + TRIG_W;

   localparam logic [ZOOM_W-1:0] ZOOM_RESET = ZOOM_W'(256);
   localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(100 * 65536);
   localparam logic [SEG_W-1:0]  SEG_BASE   = SEG_W'(4);
   localparam logic [SEG_W-1:0]  SEG_FULL   = SEG_W'(34);
   // floor(v / 10) for v below 1029
   localparam logic [7:0]        TENTH_MUL  = 8'd205;
   localparam int unsigned       TENTH_SH   = 11;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(8192);
   localparam int unsigned       TRIG_FRAC  = 14;

   localparam logic signed [COORD_W:0] COORD_MAX = (COORD_W+1)'(8388607);
   localparam logic signed [COORD_W:0] COORD_MIN = -(COORD_W+1)'(8388608);

   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic [14:0]              qsin_type;
   typedef qsin_type                 qsin_tab_type [QUARTER];

   typedef enum logic [1:0] {
      CFT_IDLE,
      CFT_DIVIDE,
      CFT_WALK
   } walk_state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic [RADIUS_W-1:0]       radius;
      logic [CAP_W-1:0]          max_points;
      logic [COLOR_W-1:0]        fill_color;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] hub_x;
      logic signed [COORD_W-1:0] hub_y;
      logic signed [COORD_W-1:0] rim_start_x;
      logic signed [COORD_W-1:0] rim_start_y;
      logic signed [COORD_W-1:0] rim_end_x;
      logic signed [COORD_W-1:0] rim_end_y;
      logic [COLOR_W-1:0]        tri_color;
      logic                      last_triangle;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic [RADIUS_W-1:0]       radius;
      logic [COLOR_W-1:0]        color;
   } ctx_type;

   // quarter-wave sine series, evaluated at elaboration only
   function automatic qsin_type quarter_sine(input longint unsigned r);
      longint unsigned a;
      longint unsigned a2;
      longint unsigned term;
      longint          sum;
      int              n;
      a    = r * 64'd1686629713 / SINE_TABLE_DEPTH;
      a2   = (a * a) >> 30;
      term = a;
      sum  = longint'(a);
      for (n = 1; n <= 7; n++) begin
         term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      sum = (sum + 32768) >>> 16;
      if (sum > 16384) begin
         sum = 16384;
      end
      return qsin_type'(sum);
   endfunction

   function automatic qsin_tab_type build_qsin();
      qsin_tab_type t;
      for (int j = 0; j < QUARTER; j++) begin
         t[j] = quarter_sine(longint'(4 * j));
      end
      return t;
   endfunction

   localparam qsin_tab_type QSIN_TAB = build_qsin();
   localparam qsin_type     QSIN_TOP = quarter_sine(longint'(SINE_TABLE_DEPTH));

   // signed sine for quadrant and offset within the quadrant
   function automatic trig_type trig_at(input logic [1:0] quad,
                                        input logic [QUARTER_W-1:0] j);
      logic [QUARTER_W:0] idx;
      qsin_type           mag;
      idx = quad[0] ? ((QUARTER_W+1)'(QUARTER) - {1'b0, j}) : {1'b0, j};
      mag = idx[QUARTER_W] ? QSIN_TOP : QSIN_TAB[idx[QUARTER_W-1:0]];
      return quad[1] ? -trig_type'({1'b0, mag}) : trig_type'({1'b0, mag});
   endfunction

endpackage
`default_nettype wire

[rtl/cft_channels.sv]
`timescale 1ns / 1ps
`default_nettype none
interface cft_req_if import cft_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface cft_rsp_if import cft_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface cft_csr_if import cft_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ZOOM_W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/circle_fan_tessellator.sv]
`timescale 1ns / 1ps
`default_nettype none
// circle fan tessellator
// req_ch takes one circle (center, radius, segment cap, color) per item;
// rsp_ch gives one triangle per item: hub, rim start, rim end, color and a
// last flag on the final triangle of the circle. csr_ch writes view_zoom and
// is always ready; the user must write it only while the block is idle, and
// the block itself does not enforce this. a circle goes through two intake
// stages (zoom multiply, segment count), then a restoring divide of the table
// depth by the count, then the angle walker emits count + 1 rim angles, one
// per cycle while rsp_ch does not stall. each angle runs the point pipe
// (table, multiply, round and saturate, pair); the first triangle shows once
// the second rim point is paired and the rest follow at the same rate. the
// walker handles one circle at a time; the intake stages can hold the next
// two circles meanwhile. a circle with zero segments gives nothing
// reset (synchronous) empties every stage and sets view_zoom to 1.0
// a stall on rsp_ch freezes the angle walk and point pipe together, nothing
// is lost or repeated; intake keeps filling until its two stages are full
module circle_fan_tessellator
   import cft_pkg::*;
#(
   parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   cft_req_if.sink    req_ch,
   cft_rsp_if.source  rsp_ch,
   cft_csr_if.sink    csr_ch
);

   localparam int unsigned NW    = $clog2(MAX_SEGMENTS + 1);
   localparam int unsigned CNT_W = $clog2(ANGLE_W + 1);
   localparam logic [ANGLE_W:0] DIVIDEND = (ANGLE_W+1)'(SINE_TABLE_DEPTH);

   `include "circle_fan_tessellator_defines.svh"

   // config register
   logic [ZOOM_W-1:0] zoom_ff;

   // intake stage 1: apparent size
   logic              f1_valid_ff;
   logic [SIZE_W-1:0] f1_size_ff;
   logic [CAP_W-1:0]  f1_cap_ff;
   ctx_type           f1_ctx_ff;
   // intake stage 2: segment count
   logic              f2_valid_ff;
   logic [NW-1:0]     f2_n_ff;
   ctx_type           f2_ctx_ff;

   logic              f1_free;
   logic              f2_free;

   // segment count math
   logic [SIZE_W+1:0] size3;
   logic [8:0]        size_pix;
   logic [15:0]       tenth_prod;
   logic [SEG_W-1:0]  seg_raw;
   logic [SEG_W-1:0]  seg_cap;
   logic [SEG_W-1:0]  seg_fin;

   // walker
   walk_state_type    state_ff;
   walk_state_type    state_in;
   logic [NW-1:0]     n_ff;
   ctx_type           w_ctx_ff;
   logic [CNT_W-1:0]  div_cnt_ff;
   logic [NW-1:0]     div_rem_ff;
   logic [ANGLE_W:0]  div_q_ff;
   logic [NW-1:0]     idx_ff;
   logic [ANGLE_W-1:0] k_ff;
   logic [NW-1:0]     frac_ff;
   logic [NW:0]       rem_sh;
   logic              rem_ge;
   logic [NW:0]       frac_sum;
   logic              frac_carry;
   logic              w_load;
   logic              w_emit;

   // pipeline advance, shared by walker and point pipe
   logic              en;

   // point pipe
   logic              p0_valid_ff, p1_valid_ff, p2_valid_ff, p3_valid_ff;
   logic              p0_first_ff, p1_first_ff, p2_first_ff, p3_first_ff;
   logic              p0_last_ff, p1_last_ff, p2_last_ff, p3_last_ff;
   ctx_type           p0_ctx_ff, p1_ctx_ff, p2_ctx_ff, p3_ctx_ff;
   logic [ANGLE_W-1:0] p0_k_ff;
   trig_type          p1_sin_ff, p1_cos_ff;
   logic signed [PROD_W-1:0] p2_px_ff, p2_py_ff;
   logic signed [COORD_W-1:0] p3_x_ff, p3_y_ff;
   logic signed [COORD_W-1:0] prev_x_ff, prev_y_ff;
   logic signed [COORD_W-1:0] rim_x, rim_y;

   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   // round to nearest at the trig scale, add the center, clamp to 24 bits
   function automatic logic signed [COORD_W-1:0] rim_point(
      input logic signed [COORD_W-1:0] center,
      input logic signed [PROD_W-1:0]  prod);
      logic signed [PROD_W-1:0]  rounded;
      logic signed [COORD_W+2:0] off;
      logic signed [COORD_W+2:0] sum;
      rounded = prod + ROUND_HALF;
      off     = (COORD_W+3)'(rounded >>> TRIG_FRAC);
      sum     = (COORD_W+3)'(center) + off;
      if (sum > (COORD_W+3)'(COORD_MAX)) begin
         sum = (COORD_W+3)'(COORD_MAX);
      end else if (sum < (COORD_W+3)'(COORD_MIN)) begin
         sum = (COORD_W+3)'(COORD_MIN);
      end
      return COORD_W'(sum);
   endfunction

   // ---------------------------------------------------------------
   // configuration
   // ---------------------------------------------------------------
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_ff <= ZOOM_RESET;
      end else if (csr_ch.valid) begin
         zoom_ff <= csr_ch.payload;
      end
   end

   // ---------------------------------------------------------------
   // intake: size = zoom * radius, then the segment count
   // ---------------------------------------------------------------
   assign f2_free      = !f2_valid_ff || w_load;
   assign f1_free      = !f1_valid_ff || f2_free;
   assign req_ch.ready = f1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (f1_free) begin
         f1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (f1_free && req_ch.valid) begin
         f1_size_ff       <= SIZE_W'(zoom_ff) * SIZE_W'(req_ch.payload.radius);
         f1_cap_ff        <= req_ch.payload.max_points;
         f1_ctx_ff.cx     <= req_ch.payload.center_x;
         f1_ctx_ff.cy     <= req_ch.payload.center_y;
         f1_ctx_ff.radius <= req_ch.payload.radius;
         f1_ctx_ff.color  <= req_ch.payload.fill_color;
      end
   end

   // below the limit, 30 * size / (100 << 16) = floor(((3 * size) >> 16) / 10)
   always_comb begin
      size3      = {2'b00, f1_size_ff} + {1'b0, f1_size_ff, 1'b0};
      size_pix   = size3[16 +: 9];
      tenth_prod = 16'(size_pix) * 16'(TENTH_MUL);
      if (f1_size_ff >= SIZE_LIMIT) begin
         seg_raw = SEG_FULL;
      end else begin
         seg_raw = SEG_BASE + SEG_W'(tenth_prod >> TENTH_SH);
      end
      seg_cap = (seg_raw > {1'b0, f1_cap_ff}) ? {1'b0, f1_cap_ff} : seg_raw;
      seg_fin = (seg_cap > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : seg_cap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else if (f2_free) begin
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f2_free && f1_valid_ff) begin
         f2_n_ff   <= NW'(seg_fin);
         f2_ctx_ff <= f1_ctx_ff;
      end
   end

   // ---------------------------------------------------------------
   // angle walker: divide depth by n, then step k by depth / n with
   // a remainder carry so k_i = round(i * depth / n)
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CFT_IDLE: begin
            if (f2_valid_ff && (f2_n_ff != '0)) begin
               state_in = CFT_DIVIDE;
            end
         end
         CFT_DIVIDE: begin
            if (div_cnt_ff == '0) begin
               state_in = CFT_WALK;
            end
         end
         CFT_WALK: begin
            if (en && (idx_ff == n_ff)) begin
               state_in = CFT_IDLE;
            end
         end
         default: state_in = CFT_IDLE;
      endcase
   end

   always_comb begin
      w_load = 1'b0;
      w_emit = 1'b0;
      unique case (state_ff)
         CFT_IDLE:   w_load = f2_valid_ff;
         CFT_DIVIDE: w_emit = 1'b0;
         CFT_WALK:   w_emit = en;
         default:    w_load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CFT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      rem_sh     = {div_rem_ff, DIVIDEND[div_cnt_ff]};
      rem_ge     = rem_sh >= {1'b0, n_ff};
      frac_sum   = {1'b0, frac_ff} + {1'b0, div_rem_ff};
      frac_carry = frac_sum >= {1'b0, n_ff};
   end

   always_ff @(posedge clock) begin
      if (w_load) begin
         n_ff       <= f2_n_ff;
         w_ctx_ff   <= f2_ctx_ff;
         div_cnt_ff <= CNT_W'(ANGLE_W);
         div_rem_ff <= '0;
         div_q_ff   <= '0;
         idx_ff     <= '0;
         k_ff       <= '0;
         frac_ff    <= f2_n_ff >> 1;
      end else if (state_ff == CFT_DIVIDE) begin
         div_rem_ff <= rem_ge ? NW'(rem_sh - {1'b0, n_ff}) : NW'(rem_sh);
         div_q_ff   <= {div_q_ff[ANGLE_W-1:0], rem_ge};
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end else if (w_emit) begin
         idx_ff  <= idx_ff + 1'b1;
         frac_ff <= frac_carry ? NW'(frac_sum - {1'b0, n_ff}) : NW'(frac_sum);
         k_ff    <= k_ff + ANGLE_W'(div_q_ff) + ANGLE_W'(frac_carry);
      end
   end

   // ---------------------------------------------------------------
   // point pipe, all stages move on en
   // ---------------------------------------------------------------
   assign en = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff  <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         p0_valid_ff  <= w_emit;
         p1_valid_ff  <= p0_valid_ff;
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_valid_ff;
         rsp_valid_ff <= p3_valid_ff && !p3_first_ff;
      end
   end

   assign rim_x = rim_point(p2_ctx_ff.cx, p2_px_ff);
   assign rim_y = rim_point(p2_ctx_ff.cy, p2_py_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         // angle index and its place in the circle
         p0_k_ff     <= k_ff;
         p0_first_ff <= idx_ff == '0;
         p0_last_ff  <= idx_ff == n_ff;
         p0_ctx_ff   <= w_ctx_ff;
         // sine and cosine (a quarter turn ahead)
         p1_sin_ff   <= trig_at(p0_k_ff[ANGLE_W-1 -: 2], p0_k_ff[QUARTER_W-1:0]);
         p1_cos_ff   <= trig_at(p0_k_ff[ANGLE_W-1 -: 2] + 2'd1,
                                p0_k_ff[QUARTER_W-1:0]);
         p1_first_ff <= p0_first_ff;
         p1_last_ff  <= p0_last_ff;
         p1_ctx_ff   <= p0_ctx_ff;
         // radius times trig
         p2_px_ff    <= $signed({1'b0, p1_ctx_ff.radius}) * p1_cos_ff;
         p2_py_ff    <= $signed({1'b0, p1_ctx_ff.radius}) * p1_sin_ff;
         p2_first_ff <= p1_first_ff;
         p2_last_ff  <= p1_last_ff;
         p2_ctx_ff   <= p1_ctx_ff;
         // rim point
         p3_x_ff     <= rim_x;
         p3_y_ff     <= rim_y;
         p3_first_ff <= p2_first_ff;
         p3_last_ff  <= p2_last_ff;
         p3_ctx_ff   <= p2_ctx_ff;
      end
   end

   // pair each rim point with the one before it
   always_ff @(posedge clock) begin
      if (en && p3_valid_ff) begin
         prev_x_ff <= p3_x_ff;
         prev_y_ff <= p3_y_ff;
         if (!p3_first_ff) begin
            rsp_ff.hub_x         <= p3_ctx_ff.cx;
            rsp_ff.hub_y         <= p3_ctx_ff.cy;
            rsp_ff.rim_start_x   <= prev_x_ff;
            rsp_ff.rim_start_y   <= prev_y_ff;
            rsp_ff.rim_end_x     <= p3_x_ff;
            rsp_ff.rim_end_y     <= p3_y_ff;
            rsp_ff.tri_color     <= p3_ctx_ff.color;
            rsp_ff.last_triangle <= p3_last_ff;
         end
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   `CFT_ASSERT_NOW(a_walk_has_segments, clock, reset, state_ff == CFT_WALK, n_ff != '0, "walking a circle with no segments")
   `CFT_ASSERT_NEXT(a_divide_ends, clock, reset, (state_ff == CFT_DIVIDE) && (div_cnt_ff == '0), state_ff == CFT_WALK, "divide did not hand over to walk")
   `CFT_ASSERT_NEXT(a_walk_ends, clock, reset, (state_ff == CFT_WALK) && en && (idx_ff == n_ff), (state_ff == CFT_IDLE) && p0_valid_ff && p0_last_ff, "closing angle not issued")
   `CFT_ASSERT_NOW(a_closing_angle, clock, reset, p0_valid_ff && p0_last_ff, p0_k_ff == '0, "closing angle is not zero")

endmodule
`default_nettype wire
